// ----- rtl/core/tksd_pkg.sv -----
// ----------------------------------------------------------------------------
// tksd_pkg
// Shared types and codes for the terminal key sequence decoder
// ----------------------------------------------------------------------------
`default_nettype none

package tksd_pkg;

    localparam int CSI_CAPACITY_DEF = 16;

    localparam int KEY_W   = 5;
    localparam int BYTES_W = 32;
    localparam int COUNT_W = 3;

    localparam logic [2:0] MODE_GROUND = 3'd0;
    localparam logic [2:0] MODE_ESC    = 3'd1;
    localparam logic [2:0] MODE_CSI    = 3'd2;
    localparam logic [2:0] MODE_SS3    = 3'd3;
    localparam logic [2:0] MODE_UTF8   = 3'd4;

    localparam logic [KEY_W-1:0] KEY_NONE        = 5'd0;
    localparam logic [KEY_W-1:0] KEY_IGNORED     = 5'd1;
    localparam logic [KEY_W-1:0] KEY_CHAR        = 5'd2;
    localparam logic [KEY_W-1:0] KEY_ENTER       = 5'd3;
    localparam logic [KEY_W-1:0] KEY_BACKSPACE   = 5'd4;
    localparam logic [KEY_W-1:0] KEY_DELETE      = 5'd5;
    localparam logic [KEY_W-1:0] KEY_LEFT        = 5'd6;
    localparam logic [KEY_W-1:0] KEY_RIGHT       = 5'd7;
    localparam logic [KEY_W-1:0] KEY_UP          = 5'd8;
    localparam logic [KEY_W-1:0] KEY_DOWN        = 5'd9;
    localparam logic [KEY_W-1:0] KEY_HOME        = 5'd10;
    localparam logic [KEY_W-1:0] KEY_END         = 5'd11;
    localparam logic [KEY_W-1:0] KEY_INTERRUPT   = 5'd12;
    localparam logic [KEY_W-1:0] KEY_EOF         = 5'd13;
    localparam logic [KEY_W-1:0] KEY_CLEAR       = 5'd14;
    localparam logic [KEY_W-1:0] KEY_KILL_LINE   = 5'd15;
    localparam logic [KEY_W-1:0] KEY_KILL_TO_END = 5'd16;
    localparam logic [KEY_W-1:0] KEY_KILL_WORD   = 5'd17;
    localparam logic [KEY_W-1:0] KEY_TAB         = 5'd18;

    typedef struct packed {
        logic [2:0]      mode;
        logic            prev_cr;
        logic [1:0]      utf8_left;
        logic [3:0][7:0] store;
        logic [2:0]      fill;
        logic [7:0]      csi_first;
    } parse_state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key_code;
        logic [BYTES_W-1:0] char_bytes;
        logic [COUNT_W-1:0] char_count;
    } key_event_t;

endpackage

`default_nettype wire

// ----- rtl/core/tksd_byte_if.sv -----
// ----------------------------------------------------------------------------
// tksd_byte_if
// Input channel: one terminal byte per word
// ----------------------------------------------------------------------------
`default_nettype none

interface tksd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tksd_key_if.sv -----
// ----------------------------------------------------------------------------
// tksd_key_if
// Output channel: one key event per word
// ----------------------------------------------------------------------------
`default_nettype none

interface tksd_key_if;
    logic        valid;
    logic        ready;
    logic [4:0]  key_code;
    logic [31:0] char_bytes;
    logic [2:0]  char_count;

    modport source (output valid, output key_code, output char_bytes, output char_count,
                    input ready);
    modport sink   (input valid, input key_code, input char_bytes, input char_count,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tksd_decode.sv -----
// ----------------------------------------------------------------------------
// tksd_decode
// Per-byte next state and key event logic
// ----------------------------------------------------------------------------
`default_nettype none

module tksd_decode #(
    parameter int CSI_CAPACITY = tksd_pkg::CSI_CAPACITY_DEF,
    parameter int CSI_CW       = $clog2(CSI_CAPACITY)
) (
    input  wire logic [7:0]            in_byte,
    input  wire tksd_pkg::parse_state_t st,
    input  wire logic [CSI_CW-1:0]     csi_count,
    output tksd_pkg::parse_state_t     st_next,
    output logic [CSI_CW-1:0]          csi_count_next,
    output tksd_pkg::key_event_t       event_next
);
    import tksd_pkg::*;

    localparam logic [CSI_CW-1:0] CSI_MAX = CSI_CW'(CSI_CAPACITY - 1);
    localparam logic [CSI_CW-1:0] CSI_ONE = CSI_CW'(1);

    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] cnt;
    logic [1:0]         left_dec;

    function automatic logic [KEY_W-1:0] arrow_home_end(input logic [7:0] b);
        logic [KEY_W-1:0] k;
        case (b)
            8'h41:   k = KEY_UP;
            8'h42:   k = KEY_DOWN;
            8'h43:   k = KEY_RIGHT;
            8'h44:   k = KEY_LEFT;
            8'h48:   k = KEY_HOME;
            8'h46:   k = KEY_END;
            default: k = KEY_IGNORED;
        endcase
        return k;
    endfunction

    always_comb
    begin
        st_next        = st;
        st_next.prev_cr = 1'b0;
        csi_count_next = csi_count;
        key            = KEY_NONE;
        left_dec       = st.utf8_left - 2'd1;
        case (st.mode)
            MODE_GROUND:
            begin
                if (in_byte inside {[8'h20:8'h7E]})
                begin
                    st_next.store[0] = in_byte;
                    st_next.fill     = 3'd1;
                    key              = KEY_CHAR;
                end
                else if (in_byte inside {[8'hC2:8'hF4]})
                begin
                    st_next.store[0]  = in_byte;
                    st_next.fill      = 3'd1;
                    st_next.utf8_left = (in_byte >= 8'hF0) ? 2'd3 :
                                        (in_byte >= 8'hE0) ? 2'd2 : 2'd1;
                    st_next.mode      = MODE_UTF8;
                end
                else
                begin
                    case (in_byte)
                        8'h0D:
                        begin
                            st_next.prev_cr = 1'b1;
                            key             = KEY_ENTER;
                        end
                        8'h0A:         key = st.prev_cr ? KEY_NONE : KEY_ENTER;
                        8'h7F, 8'h08:  key = KEY_BACKSPACE;
                        8'h1B:         st_next.mode = MODE_ESC;
                        8'h01:         key = KEY_HOME;
                        8'h05:         key = KEY_END;
                        8'h03:         key = KEY_INTERRUPT;
                        8'h04:         key = KEY_EOF;
                        8'h0C:         key = KEY_CLEAR;
                        8'h15:         key = KEY_KILL_LINE;
                        8'h0B:         key = KEY_KILL_TO_END;
                        8'h17:         key = KEY_KILL_WORD;
                        8'h09:         key = KEY_TAB;
                        default:       key = KEY_IGNORED;
                    endcase
                end
            end
            MODE_ESC:
            begin
                if (in_byte == 8'h5B)
                begin
                    st_next.mode      = MODE_CSI;
                    csi_count_next    = '0;
                    st_next.csi_first = 8'h00;
                end
                else if (in_byte == 8'h4F)
                begin
                    st_next.mode = MODE_SS3;
                end
                else
                begin
                    st_next.mode = MODE_GROUND;
                    key          = KEY_IGNORED;
                end
            end
            MODE_CSI:
            begin
                if (in_byte inside {[8'h20:8'h3F]})
                begin
                    if (csi_count < CSI_MAX)
                    begin
                        if (csi_count == '0)
                        begin
                            st_next.csi_first = in_byte;
                        end
                        csi_count_next = csi_count + CSI_ONE;
                    end
                end
                else
                begin
                    st_next.mode = MODE_GROUND;
                    if (in_byte == 8'h7E)
                    begin
                        if (csi_count != CSI_ONE)
                        begin
                            key = KEY_IGNORED;
                        end
                        else
                        begin
                            case (st.csi_first)
                                8'h31, 8'h37: key = KEY_HOME;
                                8'h34, 8'h38: key = KEY_END;
                                8'h33:        key = KEY_DELETE;
                                default:      key = KEY_IGNORED;
                            endcase
                        end
                    end
                    else if (in_byte inside {[8'h40:8'h7D]})
                    begin
                        key = arrow_home_end(in_byte);
                    end
                    else
                    begin
                        key = KEY_IGNORED;
                    end
                end
            end
            MODE_SS3:
            begin
                st_next.mode = MODE_GROUND;
                key          = arrow_home_end(in_byte);
            end
            MODE_UTF8:
            begin
                if (in_byte inside {[8'h80:8'hBF]})
                begin
                    if (st.fill < 3'd4)
                    begin
                        st_next.store[st.fill[1:0]] = in_byte;
                        st_next.fill                = st.fill + 3'd1;
                    end
                    st_next.utf8_left = left_dec;
                    if (left_dec == 2'd0)
                    begin
                        st_next.mode = MODE_GROUND;
                        key          = KEY_CHAR;
                    end
                end
                else
                begin
                    st_next.utf8_left = 2'd0;
                    st_next.mode      = MODE_GROUND;
                    key               = KEY_IGNORED;
                end
            end
            default:
            begin
                st_next.mode = MODE_GROUND;
                key          = KEY_IGNORED;
            end
        endcase
    end

    always_comb
    begin
        cnt = 3'd0;
        if (key == KEY_CHAR)
        begin
            cnt = (st_next.fill > 3'd4) ? 3'd4 : st_next.fill;
        end
        event_next.key_code   = key;
        event_next.char_count = cnt;
        for (int i = 0; i < 4; i++)
        begin
            event_next.char_bytes[8*i +: 8] = (COUNT_W'(i) < cnt) ? st_next.store[i] : 8'h00;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tksd_result_reg.sv -----
// ----------------------------------------------------------------------------
// tksd_result_reg
// Output register holding one key event until the sink takes it
// ----------------------------------------------------------------------------
`default_nettype none

module tksd_result_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire tksd_pkg::key_event_t event_in,
    output logic                      can_load,
    tksd_key_if.source                key_ch
);
    import tksd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    key_event_t event_reg;

    assign can_load   = !valid_reg || key_ch.ready;
    assign valid_next = load || (valid_reg && !key_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            event_reg <= event_in;
        end
    end

    assign key_ch.valid      = valid_reg;
    assign key_ch.key_code   = event_reg.key_code;
    assign key_ch.char_bytes = event_reg.char_bytes;
    assign key_ch.char_count = event_reg.char_count;

endmodule

`default_nettype wire

// ----- rtl/core/terminal_key_sequence_decoder_core.sv -----
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder_core
// Turns a terminal byte stream into key events, one event per byte
// ----------------------------------------------------------------------------
// Every byte taken on byte_ch gives exactly one word on key_ch, in the cycle
// after it is taken. A byte is taken in every cycle in which the output
// register is empty or its word is being taken, so a stream flows at one
// byte per clock; the parse state, the CSI count and the output register
// are the only storage. No clearing pass is needed after reset.
`default_nettype none

module terminal_key_sequence_decoder_core #(
    parameter int CSI_CAPACITY = tksd_pkg::CSI_CAPACITY_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tksd_byte_if.sink  byte_ch,
    tksd_key_if.source key_ch
);
    import tksd_pkg::*;

    localparam int CSI_CW = $clog2(CSI_CAPACITY);

    parse_state_t      state_reg;
    parse_state_t      state_next;
    logic [CSI_CW-1:0] csi_count_reg;
    logic [CSI_CW-1:0] csi_count_next;
    key_event_t        event_next;
    logic              can_load;
    logic              accept;

    assign byte_ch.ready = can_load;
    assign accept        = byte_ch.valid && can_load;

    tksd_decode #(
        .CSI_CAPACITY (CSI_CAPACITY),
        .CSI_CW       (CSI_CW)
    ) u_decode (
        .in_byte        (byte_ch.in_byte),
        .st             (state_reg),
        .csi_count      (csi_count_reg),
        .st_next        (state_next),
        .csi_count_next (csi_count_next),
        .event_next     (event_next)
    );

    tksd_result_reg u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .event_in (event_next),
        .can_load (can_load),
        .key_ch   (key_ch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            csi_count_reg <= '0;
        end
        else if (accept)
        begin
            state_reg     <= state_next;
            csi_count_reg <= csi_count_next;
        end
    end

    // a stalled word blocks the input
    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        key_ch.valid && !key_ch.ready |-> !byte_ch.ready)
        else $error("byte taken while output word stalled");

    // every byte taken gives a word next cycle
    a_byte_gives_word : assert property (@(posedge clk) disable iff (!rst_n)
        byte_ch.valid && byte_ch.ready |=> key_ch.valid)
        else $error("byte taken without a key word");

    a_char_has_bytes : assert property (@(posedge clk) disable iff (!rst_n)
        key_ch.valid && key_ch.key_code == KEY_CHAR |->
            key_ch.char_count != 3'd0 && key_ch.char_count <= 3'd4)
        else $error("char event with bad byte count");

    a_fill_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.fill <= 3'd4 && state_reg.mode <= MODE_UTF8)
        else $error("parse state out of range");

    a_csi_saturates : assert property (@(posedge clk) disable iff (!rst_n)
        csi_count_reg <= CSI_CW'(CSI_CAPACITY - 1))
        else $error("csi count past capacity");

endmodule

`default_nettype wire

// ----- tb/terminal_key_sequence_decoder_core_tb.sv -----
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder_core_tb
// Self-checking bench for the terminal key sequence decoder
// ----------------------------------------------------------------------------
// A short table of bytes covers the printable range edges, CR LF folding,
// bytes with no meaning, a CSI delete, an SS3 arrow and UTF-8 characters,
// including a broken one. It is followed by about 600 random bytes. These are
// built mostly from well-formed key, escape and UTF-8 sequences with random
// content, with broken sequences and raw noise mixed in. A local decoder
// predicts the key event for every byte that is taken. Each word on the key
// channel is checked field by field against the oldest prediction. The
// sender works in random bursts and the receiver stalls in patterns of its
// own. One long receiver hold lets the block back up into its input, and
// one sender pause lets the block drain completely.
// ----------------------------------------------------------------------------

module terminal_key_sequence_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tksd_pkg::*;

    localparam int PARAM_CAP    = CSI_CAPACITY_DEF;
    localparam int RANDOM_BYTES = 600;
    localparam int DRAIN_AT     = 420;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 80;

    localparam logic [7:0] B_ESC       = 8'h1B;
    localparam logic [7:0] B_CR        = 8'h0D;
    localparam logic [7:0] B_LF        = 8'h0A;
    localparam logic [7:0] B_DEL       = 8'h7F;
    localparam logic [7:0] B_BS        = 8'h08;
    localparam logic [7:0] B_TAB       = 8'h09;
    localparam logic [7:0] CTRL_A      = 8'h01;
    localparam logic [7:0] CTRL_C      = 8'h03;
    localparam logic [7:0] CTRL_D      = 8'h04;
    localparam logic [7:0] CTRL_E      = 8'h05;
    localparam logic [7:0] CTRL_K      = 8'h0B;
    localparam logic [7:0] CTRL_L      = 8'h0C;
    localparam logic [7:0] CTRL_U      = 8'h15;
    localparam logic [7:0] CTRL_W      = 8'h17;
    localparam logic [7:0] B_CSI_INTRO = "[";
    localparam logic [7:0] B_SS3_INTRO = "O";
    localparam logic [7:0] B_TILDE     = "~";
    localparam logic [7:0] FIN_UP      = "A";
    localparam logic [7:0] FIN_DOWN    = "B";
    localparam logic [7:0] FIN_RIGHT   = "C";
    localparam logic [7:0] FIN_LEFT    = "D";
    localparam logic [7:0] FIN_HOME    = "H";
    localparam logic [7:0] FIN_END     = "F";
    localparam logic [7:0] DIG_HOME1   = "1";
    localparam logic [7:0] DIG_HOME7   = "7";
    localparam logic [7:0] DIG_END4    = "4";
    localparam logic [7:0] DIG_END8    = "8";
    localparam logic [7:0] DIG_DEL     = "3";

    typedef struct packed {
        logic [7:0] data;
        logic       pinned;
        key_event_t want;
    } stim_row_t;

    typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_ROTATE} rx_style_t;

    logic clk;
    logic rst_n;

    tksd_byte_if byte_ch();
    tksd_key_if  key_ch();

    terminal_key_sequence_decoder_core #(
        .CSI_CAPACITY(PARAM_CAP)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .byte_ch(byte_ch),
        .key_ch (key_ch)
    );

    stim_row_t directed_rows [26] = '{
        '{8'h20,       1'b1, '{KEY_CHAR,      32'h0000_0020, 3'd1}},
        '{8'h7E,       1'b1, '{KEY_CHAR,      32'h0000_007E, 3'd1}},
        '{B_CR,        1'b1, '{KEY_ENTER,     32'h0,         3'd0}},
        '{B_LF,        1'b1, '{KEY_NONE,      32'h0,         3'd0}},
        '{B_LF,        1'b1, '{KEY_ENTER,     32'h0,         3'd0}},
        '{B_DEL,       1'b1, '{KEY_BACKSPACE, 32'h0,         3'd0}},
        '{8'h00,       1'b1, '{KEY_IGNORED,   32'h0,         3'd0}},
        '{8'hFF,       1'b1, '{KEY_IGNORED,   32'h0,         3'd0}},
        '{8'hC1,       1'b1, '{KEY_IGNORED,   32'h0,         3'd0}},
        '{B_ESC,       1'b1, '{KEY_NONE,      32'h0,         3'd0}},
        '{B_CSI_INTRO, 1'b0, '0},
        '{DIG_DEL,     1'b0, '0},
        '{B_TILDE,     1'b1, '{KEY_DELETE,    32'h0,         3'd0}},
        '{B_ESC,       1'b0, '0},
        '{B_SS3_INTRO, 1'b0, '0},
        '{FIN_LEFT,    1'b1, '{KEY_LEFT,      32'h0,         3'd0}},
        '{8'hF4,       1'b0, '0},
        '{8'h8F,       1'b0, '0},
        '{8'hBF,       1'b0, '0},
        '{8'h80,       1'b1, '{KEY_CHAR,      32'h80BF_8FF4, 3'd4}},
        '{8'hC2,       1'b0, '0},
        '{8'hBF,       1'b1, '{KEY_CHAR,      32'h0000_BFC2, 3'd2}},
        '{8'hE2,       1'b0, '0},
        '{8'h41,       1'b1, '{KEY_IGNORED,   32'h0,         3'd0}},
        '{B_ESC,       1'b0, '0},
        '{8'h78,       1'b1, '{KEY_IGNORED,   32'h0,         3'd0}}
    };

    logic [7:0] ctl_keys [13] = '{B_CR, B_LF, B_DEL, B_BS, CTRL_A, CTRL_E, CTRL_C,
                                  CTRL_D, CTRL_L, CTRL_U, CTRL_K, CTRL_W, B_TAB};
    logic [7:0] seq_finals [7] = '{FIN_UP, FIN_DOWN, FIN_RIGHT, FIN_LEFT, FIN_HOME,
                                   FIN_END, B_TILDE};
    logic [7:0] param_digits [7] = '{DIG_HOME1, "2", DIG_DEL, DIG_END4, "5",
                                     DIG_HOME7, DIG_END8};

    stim_row_t  byte_stream [$];
    key_event_t pending_keys [$];

    int  bytes_taken  = 0;
    int  results_seen = 0;
    int  errors       = 0;
    bit  stream_done  = 1'b0;
    int  n_chars      = 0;
    int  n_wide       = 0;
    int  n_nav        = 0;
    int  n_ignored    = 0;

    // decoder state as seen from outside
    logic [2:0]      scan_mode   = MODE_GROUND;
    logic            cr_seen     = 1'b0;
    logic [1:0]      cont_left   = 2'd0;
    logic [3:0][7:0] glyph       = '0;
    logic [2:0]      glyph_len   = 3'd0;
    logic [5:0]      param_count = 6'd0;
    logic [7:0]      param_lead  = 8'd0;

    function automatic logic [KEY_W-1:0] final_key(input logic [7:0] b);
        case (b)
            FIN_UP:    return KEY_UP;
            FIN_DOWN:  return KEY_DOWN;
            FIN_RIGHT: return KEY_RIGHT;
            FIN_LEFT:  return KEY_LEFT;
            FIN_HOME:  return KEY_HOME;
            FIN_END:   return KEY_END;
            default:   return KEY_IGNORED;
        endcase
    endfunction

    function automatic key_event_t decode_byte(input logic [7:0] b);
        key_event_t       ev;
        logic [KEY_W-1:0] k;
        logic             had_cr;
        int               n;
        ev     = '0;
        k      = KEY_IGNORED;
        had_cr = cr_seen;
        cr_seen = 1'b0;
        case (scan_mode)
            MODE_GROUND:
            begin
                if (b >= 8'h20 && b < B_DEL)
                begin
                    glyph[0]  = b;
                    glyph_len = 3'd1;
                    k = KEY_CHAR;
                end
                else if (b >= 8'hC2 && b <= 8'hF4)
                begin
                    glyph[0]  = b;
                    glyph_len = 3'd1;
                    cont_left = (b >= 8'hF0) ? 2'd3 : (b >= 8'hE0) ? 2'd2 : 2'd1;
                    scan_mode = MODE_UTF8;
                    k = KEY_NONE;
                end
                else
                begin
                    case (b)
                        B_CR:
                        begin
                            cr_seen = 1'b1;
                            k = KEY_ENTER;
                        end
                        B_LF:         k = had_cr ? KEY_NONE : KEY_ENTER;
                        B_DEL, B_BS:  k = KEY_BACKSPACE;
                        B_ESC:
                        begin
                            scan_mode = MODE_ESC;
                            k = KEY_NONE;
                        end
                        CTRL_A:       k = KEY_HOME;
                        CTRL_E:       k = KEY_END;
                        CTRL_C:       k = KEY_INTERRUPT;
                        CTRL_D:       k = KEY_EOF;
                        CTRL_L:       k = KEY_CLEAR;
                        CTRL_U:       k = KEY_KILL_LINE;
                        CTRL_K:       k = KEY_KILL_TO_END;
                        CTRL_W:       k = KEY_KILL_WORD;
                        B_TAB:        k = KEY_TAB;
                        default:      k = KEY_IGNORED;
                    endcase
                end
            end
            MODE_ESC:
            begin
                if (b == B_CSI_INTRO)
                begin
                    scan_mode   = MODE_CSI;
                    param_count = 6'd0;
                    param_lead  = 8'd0;
                    k = KEY_NONE;
                end
                else if (b == B_SS3_INTRO)
                begin
                    scan_mode = MODE_SS3;
                    k = KEY_NONE;
                end
                else
                begin
                    scan_mode = MODE_GROUND;
                    k = KEY_IGNORED;
                end
            end
            MODE_CSI:
            begin
                if (b >= 8'h20 && b <= 8'h3F)
                begin
                    // parameter bytes are counted only up to one below the capacity
                    if (int'(param_count) < PARAM_CAP - 1)
                    begin
                        if (param_count == 6'd0)
                            param_lead = b;
                        param_count = param_count + 6'd1;
                    end
                    k = KEY_NONE;
                end
                else
                begin
                    scan_mode = MODE_GROUND;
                    if (b < 8'h40 || b > B_TILDE)
                        k = KEY_IGNORED;
                    else if (b != B_TILDE)
                        k = final_key(b);
                    else if (param_count != 6'd1)
                        k = KEY_IGNORED;
                    else
                    begin
                        case (param_lead)
                            DIG_HOME1, DIG_HOME7: k = KEY_HOME;
                            DIG_END4, DIG_END8:   k = KEY_END;
                            DIG_DEL:              k = KEY_DELETE;
                            default:              k = KEY_IGNORED;
                        endcase
                    end
                end
            end
            MODE_SS3:
            begin
                scan_mode = MODE_GROUND;
                k = final_key(b);
            end
            MODE_UTF8:
            begin
                if (b >= 8'h80 && b <= 8'hBF)
                begin
                    if (glyph_len < 3'd4)
                    begin
                        glyph[glyph_len[1:0]] = b;
                        glyph_len = glyph_len + 3'd1;
                    end
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0)
                    begin
                        scan_mode = MODE_GROUND;
                        k = KEY_CHAR;
                    end
                    else
                        k = KEY_NONE;
                end
                else
                begin
                    cont_left = 2'd0;
                    scan_mode = MODE_GROUND;
                    k = KEY_IGNORED;
                end
            end
            default:
            begin
                scan_mode = MODE_GROUND;
                k = KEY_IGNORED;
            end
        endcase
        ev.key_code = k;
        if (k == KEY_CHAR)
        begin
            n = (glyph_len > 3'd4) ? 4 : int'(glyph_len);
            for (int i = 0; i < n; i++)
                ev.char_bytes[8*i +: 8] = glyph[i];
            ev.char_count = n[2:0];
        end
        return ev;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        byte_stream.push_back('{b, 1'b0, '0});
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // stream builder and sender
    initial
    begin
        int unsigned pick;
        int unsigned lead_cls;
        int unsigned sel;
        int unsigned fsel;
        int unsigned n;
        logic [7:0]  lead;
        int          pos;
        int          burst_left;
        int          gap_left;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= 8'h00;
        foreach (directed_rows[i])
            byte_stream.push_back(directed_rows[i]);
        while (byte_stream.size() < $size(directed_rows) + RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                add_byte(8'($urandom_range(8'h20, 8'h7E)));
            else if (pick < 32)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    add_byte(B_CR);
                    add_byte(B_LF);
                end
                else
                    add_byte(ctl_keys[4'($urandom_range(0, 12))]);
            end
            else if (pick < 56)
            begin
                // utf-8 character, broken short of its length from 50 up
                lead_cls = $urandom_range(1, 3);
                case (lead_cls)
                    1:       lead = 8'($urandom_range(8'hC2, 8'hDF));
                    2:       lead = 8'($urandom_range(8'hE0, 8'hEF));
                    default: lead = 8'($urandom_range(8'hF0, 8'hF4));
                endcase
                add_byte(lead);
                n = (pick < 50) ? lead_cls : $urandom_range(0, lead_cls - 1);
                repeat (n)
                    add_byte(8'($urandom_range(8'h80, 8'hBF)));
                if (pick >= 50)
                    add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h7F))
                                                  : 8'($urandom_range(8'hC0, 8'hFF)));
            end
            else if (pick < 76)
            begin
                add_byte(B_ESC);
                add_byte(B_CSI_INTRO);
                sel  = $urandom_range(0, 2);
                fsel = $urandom_range(0, 9);
                if (sel == 1)
                    add_byte(param_digits[3'($urandom_range(0, 6))]);
                else if (sel == 2)
                    repeat ($urandom_range(1, 20))
                        add_byte(8'($urandom_range(8'h20, 8'h3F)));
                if (sel == 1 && fsel < 5)
                    add_byte(B_TILDE);
                else if (fsel < 6)
                    add_byte(seq_finals[3'($urandom_range(0, 6))]);
                else if (fsel < 9)
                    add_byte(8'($urandom_range(8'h40, 8'h7E)));
                else
                    add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h1F))
                                                  : 8'($urandom_range(8'h80, 8'hFF)));
            end
            else if (pick < 84)
            begin
                add_byte(B_ESC);
                add_byte(B_SS3_INTRO);
                if ($urandom_range(0, 9) < 7)
                    add_byte(seq_finals[3'($urandom_range(0, 5))]);
                else
                    add_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 88)
            begin
                add_byte(B_ESC);
                add_byte(8'($urandom_range(0, 255)));
            end
            else
                add_byte(8'($urandom_range(0, 255)));
        end

        wait (rst_n === 1'b1);
        @(posedge clk);
        pos        = 0;
        burst_left = $urandom_range(1, 30);
        gap_left   = 0;
        while (pos < byte_stream.size())
        begin
            if (pos == DRAIN_AT && results_seen != pos)
                byte_ch.valid <= 1'b0;
            else if (gap_left > 0)
            begin
                byte_ch.valid <= 1'b0;
                gap_left--;
            end
            else
            begin
                byte_ch.valid   <= 1'b1;
                byte_ch.in_byte <= byte_stream[pos].data;
            end
            @(posedge clk);
            if (byte_ch.valid && byte_ch.ready)
            begin
                pos++;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        byte_ch.valid <= 1'b0;
        stream_done = 1'b1;
    end

    // receiver
    initial
    begin
        rx_style_t  style;
        int         phase_left;
        int         hold_left;
        bit         held;
        logic [7:0] mask;
        logic       next_ready;
        key_ch.ready <= 1'b0;
        style      = RX_FLOW;
        phase_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        mask       = 8'hFF;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0, 1:    style = RX_FLOW;
                        2:       style = RX_COIN;
                        default: style = RX_ROTATE;
                    endcase
                    phase_left = $urandom_range(16, 80);
                    mask       = 8'($urandom_range(0, 255));
                end
                phase_left--;
                case (style)
                    RX_FLOW:  next_ready = 1'b1;
                    RX_COIN:  next_ready = 1'($urandom_range(0, 1));
                    default:
                    begin
                        next_ready = mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                endcase
            end
            key_ch.ready <= next_ready;
        end
    end

    // predict on every byte taken
    always @(posedge clk)
    begin
        key_event_t model_ev;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            model_ev = decode_byte(byte_ch.in_byte);
            if (byte_stream[bytes_taken].pinned)
                pending_keys.push_back(byte_stream[bytes_taken].want);
            else
                pending_keys.push_back(model_ev);
            bytes_taken++;
        end
    end

    // check every key word taken
    always @(posedge clk)
    begin
        key_event_t got;
        key_event_t want;
        if (rst_n && key_ch.valid && key_ch.ready)
        begin
            got = {key_ch.key_code, key_ch.char_bytes, key_ch.char_count};
            results_seen++;
            if (pending_keys.size() == 0)
            begin
                $display("%0t: key word with nothing expected: key_code %0d", $time,
                         got.key_code);
                errors++;
            end
            else
            begin
                want = pending_keys.pop_front();
                if (got.key_code !== want.key_code)
                begin
                    $display("%0t: key_code expected %0d got %0d", $time,
                             want.key_code, got.key_code);
                    errors++;
                end
                if (got.char_bytes !== want.char_bytes)
                begin
                    $display("%0t: char_bytes expected %h got %h", $time,
                             want.char_bytes, got.char_bytes);
                    errors++;
                end
                if (got.char_count !== want.char_count)
                begin
                    $display("%0t: char_count expected %0d got %0d", $time,
                             want.char_count, got.char_count);
                    errors++;
                end
                case (want.key_code)
                    KEY_CHAR:
                    begin
                        n_chars++;
                        if (want.char_count > 3'd1)
                            n_wide++;
                    end
                    KEY_DELETE, KEY_LEFT, KEY_RIGHT, KEY_UP, KEY_DOWN, KEY_HOME, KEY_END:
                        n_nav++;
                    KEY_IGNORED:
                        n_ignored++;
                    default:
                        ;
                endcase
            end
        end
    end

    initial
    begin
        int spin;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (stream_done);
        spin = 0;
        while (results_seen != bytes_taken && spin < 5000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (8) @(posedge clk);
        if (pending_keys.size() != 0)
        begin
            $display("%0t: %0d key words expected but never seen", $time,
                     pending_keys.size());
            errors += pending_keys.size();
        end
        $display("run: %0d bytes in, %0d key words out, %0d mismatches", bytes_taken,
                 results_seen, errors);
        $display("run: %0d characters (%0d multi-byte), %0d cursor or delete keys, %0d ignored",
                 n_chars, n_wide, n_nav, n_ignored);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/tksd_pkg.sv
rtl/core/tksd_byte_if.sv
rtl/core/tksd_key_if.sv
rtl/core/tksd_decode.sv
rtl/core/tksd_result_reg.sv
rtl/core/terminal_key_sequence_decoder_core.sv
tb/terminal_key_sequence_decoder_core_tb.sv
